>>> src/ffba_pkg.sv
package ffba_pkg;

  localparam int HEAP_BLOCKS_DEF = 4096;
  localparam int BLOCK_SHIFT = 3;
  localparam int REQ_W = 16;
  localparam int BLK_W = 14;
  localparam int STATUS_W = 2;
  localparam int ADDR_W = 32;
  localparam int OUT_IDX_W = 12;
  localparam int SIZE_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd3;

  localparam logic ACT_INIT  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 1'b1;

  localparam logic [SIZE_W-1:0] HEAP_SIZE_RESET = 16'd32768;

  typedef struct packed {
    logic                latch_in;
    logic                init_write;
    logic                rd_issue;
    logic                go_next;
    logic                split_write;
    logic                hdr_write;
    logic                set_ready;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic heap_ready;
    logic zero_req;
    logic fit;
    logic can_link;
    logic out_free;
  } sts_t;

endpackage

>>> src/ffba_ctrl.sv
module ffba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [ffba_pkg::STATUS_W-1:0] res;
  logic [ffba_pkg::STATUS_W-1:0] res_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    res_next = res;
    cmd = '0;
    cmd.out_status = res;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.action == ffba_pkg::ACT_INIT) begin
          cmd.init_write = 1'b1;
          cmd.set_ready = 1'b1;
          res_next = ffba_pkg::ST_OK;
          state_next = S_FINISH;
        end else if (!sts.heap_ready) begin
          res_next = ffba_pkg::ST_NOT_READY;
          state_next = S_FINISH;
        end else if (sts.zero_req) begin
          res_next = ffba_pkg::ST_ZERO_SIZE;
          state_next = S_FINISH;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.fit) begin
          cmd.split_write = 1'b1;
          state_next = S_UPDATE;
        end else if (sts.can_link) begin
          cmd.go_next = 1'b1;
          cmd.rd_issue = 1'b1;
        end else begin
          res_next = ffba_pkg::ST_NO_FIT;
          state_next = S_FINISH;
        end
      end
      S_UPDATE: begin
        cmd.hdr_write = 1'b1;
        res_next = ffba_pkg::ST_OK;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res <= ffba_pkg::ST_OK;
    end else begin
      state <= state_next;
      res <= res_next;
    end
  end

endmodule

>>> src/ffba_datapath.sv
module ffba_datapath #(
  parameter int HEAP_BLOCKS = ffba_pkg::HEAP_BLOCKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ffba_pkg::cmd_t                    cmd,
  output ffba_pkg::sts_t                    sts,
  input  logic                              action,
  input  logic [ffba_pkg::REQ_W-1:0]        request_bytes,
  input  logic                              cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0]       cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ffba_pkg::STATUS_W-1:0]     status,
  output logic [ffba_pkg::OUT_IDX_W-1:0]    block_index,
  output logic [ffba_pkg::ADDR_W-1:0]       address
);

  localparam int IDX_W = (HEAP_BLOCKS > 1) ? $clog2(HEAP_BLOCKS) : 1;
  localparam int CW = ((IDX_W > ffba_pkg::BLK_W) ? IDX_W : ffba_pkg::BLK_W) + 2;
  localparam logic [CW-1:0] BLOCKS_C = CW'(HEAP_BLOCKS);

  typedef struct packed {
    logic [IDX_W-1:0] size;
    logic             occupied;
    logic             has_next;
    logic [IDX_W-1:0] next;
  } hdr_t;

  hdr_t mem [HEAP_BLOCKS];
  hdr_t rd_q;

  logic [ffba_pkg::ADDR_W-1:0] heap_base;
  logic [ffba_pkg::SIZE_W-1:0] heap_size_bytes;
  logic heap_ready;
  logic act_q;
  logic [ffba_pkg::REQ_W-1:0] req_q;
  logic [IDX_W-1:0] cur;

  logic [ffba_pkg::BLK_W-1:0] blocks;
  logic [CW-1:0] blocks_c;
  logic [CW-1:0] size_c;
  logic [CW-1:0] nidx_c;
  logic [CW-1:0] total_c;
  logic [CW-1:0] total_sat;
  logic [IDX_W-1:0] init_size;
  logic split_ok;

  logic mem_we;
  logic [IDX_W-1:0] mem_waddr;
  hdr_t mem_wdata;
  hdr_t init_hdr;
  hdr_t split_hdr;
  hdr_t upd_hdr;
  logic [IDX_W-1:0] rd_addr;
  logic [ffba_pkg::ADDR_W-1:0] cur_ext;
  logic out_zero;

  assign blocks = ffba_pkg::BLK_W'(req_q >> ffba_pkg::BLOCK_SHIFT) + 1'b1;
  assign blocks_c = CW'(blocks);
  assign size_c = CW'(rd_q.size);
  assign nidx_c = CW'(cur) + blocks_c + 1'b1;
  assign split_ok = (blocks_c < size_c) && (nidx_c < BLOCKS_C);

  assign total_c = CW'(heap_size_bytes >> ffba_pkg::BLOCK_SHIFT);
  assign total_sat = (total_c > BLOCKS_C) ? BLOCKS_C : total_c;
  assign init_size = (total_sat != '0) ? IDX_W'(total_sat - 1'b1) : '0;

  assign sts.action = act_q;
  assign sts.heap_ready = heap_ready;
  assign sts.zero_req = (req_q == '0);
  assign sts.fit = !rd_q.occupied && (blocks_c <= size_c);
  assign sts.can_link = rd_q.has_next && (CW'(rd_q.next) < BLOCKS_C);
  assign sts.out_free = !out_valid || out_ready;

  always_comb begin
    init_hdr = '0;
    init_hdr.size = init_size;

    split_hdr.size = IDX_W'(size_c - blocks_c - 1'b1);
    split_hdr.occupied = 1'b0;
    split_hdr.has_next = rd_q.has_next;
    split_hdr.next = rd_q.next;

    upd_hdr.size = IDX_W'(blocks_c);
    upd_hdr.occupied = 1'b1;
    upd_hdr.has_next = split_ok ? 1'b1 : rd_q.has_next;
    upd_hdr.next = split_ok ? IDX_W'(nidx_c) : rd_q.next;

    mem_we = 1'b0;
    mem_waddr = cur;
    mem_wdata = upd_hdr;
    if (cmd.init_write) begin
      mem_we = 1'b1;
      mem_waddr = '0;
      mem_wdata = init_hdr;
    end else if (cmd.split_write) begin
      mem_we = split_ok;
      mem_waddr = IDX_W'(nidx_c);
      mem_wdata = split_hdr;
    end else if (cmd.hdr_write) begin
      mem_we = 1'b1;
    end
  end

  assign rd_addr = cmd.go_next ? rd_q.next : cur;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_issue) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_q <= action;
      req_q <= request_bytes;
      cur <= '0;
    end else if (cmd.go_next) begin
      cur <= rd_q.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
      heap_size_bytes <= ffba_pkg::HEAP_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ffba_pkg::CFG_HEAP_BASE: heap_base <= cfg_data;
        ffba_pkg::CFG_HEAP_SIZE: heap_size_bytes <= cfg_data[ffba_pkg::SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_ready <= 1'b0;
    end else if (cmd.set_ready) begin
      heap_ready <= 1'b1;
    end
  end

  assign cur_ext = ffba_pkg::ADDR_W'(cur);
  assign out_zero = (cmd.out_status != ffba_pkg::ST_OK) || (act_q == ffba_pkg::ACT_INIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_status;
      block_index <= out_zero ? '0 : cur_ext[ffba_pkg::OUT_IDX_W-1:0];
      address <= out_zero ? '0 :
                 heap_base + ((cur_ext + 1'b1) << ffba_pkg::BLOCK_SHIFT);
    end
  end

endmodule

>>> src/first_fit_block_allocator.sv
// Init, not-ready and zero-size words go from DECODE straight to FINISH for output.
// A failed allocate walks headers in CHECK, then goes to FINISH; a successful one
// passes UPDATE first; the walk reads one header per cycle from the header memory.
// A result that is not taken holds the controller until the output register frees.
// One word is in work at a time; the next is accepted once the result has loaded.
// Reset covers the control state, heap_ready, out_valid and the config; not the headers.
module first_fit_block_allocator #(
  parameter int HEAP_BLOCKS = ffba_pkg::HEAP_BLOCKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [ffba_pkg::REQ_W-1:0]        request_bytes,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ffba_pkg::STATUS_W-1:0]     status,
  output logic [ffba_pkg::OUT_IDX_W-1:0]    block_index,
  output logic [ffba_pkg::ADDR_W-1:0]       address,
  input  logic                              cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0]       cfg_data
);

  ffba_pkg::cmd_t cmd;
  ffba_pkg::sts_t sts;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffba_datapath #(
    .HEAP_BLOCKS (HEAP_BLOCKS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (action),
    .request_bytes (request_bytes),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .block_index   (block_index),
    .address       (address)
  );

endmodule

>>> dv/first_fit_block_allocator_tb.sv
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 12;
  localparam int WORDS_PER_PHASE = 75;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] block_index;
    logic [ADDR_W-1:0]    address;
  } alloc_result_t;

  class heap_scoreboard;
    int unsigned       node_size [HEAP_BLOCKS_DEF];
    bit                node_busy [HEAP_BLOCKS_DEF];
    bit                node_linked [HEAP_BLOCKS_DEF];
    int unsigned       node_next [HEAP_BLOCKS_DEF];
    bit                heap_ready;
    logic [ADDR_W-1:0] heap_base;
    logic [SIZE_W-1:0] heap_size_bytes;
    alloc_result_t     expected_q[$];
    int                mismatches;

    function new();
      heap_ready = 1'b0;
      heap_base = '0;
      heap_size_bytes = HEAP_SIZE_RESET;
      mismatches = 0;
    endfunction

    function void set_regs(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size_bytes);
      heap_base = base;
      heap_size_bytes = size_bytes;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_word(logic act, logic [REQ_W-1:0] req);
      int unsigned   total;
      int unsigned   blocks;
      int unsigned   cur;
      int unsigned   steps;
      int unsigned   nidx;
      bit            found;
      alloc_result_t r;
      r.status = ST_OK;
      r.block_index = '0;
      r.address = '0;
      if (act == ACT_INIT) begin
        total = int'(heap_size_bytes >> BLOCK_SHIFT);
        if (total > HEAP_BLOCKS_DEF) total = HEAP_BLOCKS_DEF;
        node_size[0] = (total != 0) ? total - 1 : 0;
        node_busy[0] = 1'b0;
        node_linked[0] = 1'b0;
        node_next[0] = 0;
        heap_ready = 1'b1;
      end else if (!heap_ready) begin
        r.status = ST_NOT_READY;
      end else if (req == 0) begin
        r.status = ST_ZERO_SIZE;
      end else begin
        blocks = (req >> BLOCK_SHIFT) + 1;
        cur = 0;
        steps = 0;
        found = 1'b0;
        while (1) begin
          if (!node_busy[cur] && blocks <= node_size[cur]) begin
            found = 1'b1;
            break;
          end
          steps++;
          if (!node_linked[cur] || node_next[cur] >= HEAP_BLOCKS_DEF ||
              steps >= HEAP_BLOCKS_DEF) break;
          cur = node_next[cur];
        end
        if (!found) begin
          r.status = ST_NO_FIT;
        end else begin
          if (blocks < node_size[cur]) begin
            nidx = cur + blocks + 1;
            if (nidx < HEAP_BLOCKS_DEF) begin
              node_size[nidx] = node_size[cur] - (blocks + 1);
              node_busy[nidx] = 1'b0;
              node_linked[nidx] = node_linked[cur];
              node_next[nidx] = node_next[cur];
              node_linked[cur] = 1'b1;
              node_next[cur] = nidx;
            end
          end
          node_size[cur] = blocks;
          node_busy[cur] = 1'b1;
          r.block_index = cur[OUT_IDX_W-1:0];
          r.address = heap_base + ADDR_W'((cur + 1) << BLOCK_SHIFT);
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [OUT_IDX_W-1:0] idx,
                               logic [ADDR_W-1:0] addr);
      alloc_result_t r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d index %0d address %h", st, idx, addr);
        return;
      end
      r = expected_q.pop_front();
      if (st !== r.status || idx !== r.block_index || addr !== r.address) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d index %0d address %h, got %0d %0d %h",
                   r.status, r.block_index, r.address, st, idx, addr);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 action = ACT_INIT;
  logic [REQ_W-1:0]     request_bytes = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [OUT_IDX_W-1:0] block_index;
  logic [ADDR_W-1:0]    address;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_HEAP_BASE;
  logic [ADDR_W-1:0]    cfg_data = '0;

  heap_scoreboard sb = new();
  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  bit             rx_hold_req = 1'b0;
  int             rx_hold_left = 0;
  int             cycle_count = 0;
  int             words_sent = 0;

  first_fit_block_allocator uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .request_bytes(request_bytes),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .block_index(block_index),
    .address(address),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(status, block_index, address);
  end

  task automatic send_word(logic act, logic [REQ_W-1:0] req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    request_bytes <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_word(act, req);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  task automatic set_config(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size_bytes);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HEAP_BASE;
    cfg_data <= base;
    @(negedge clk);
    cfg_index <= CFG_HEAP_SIZE;
    cfg_data <= ADDR_W'(size_bytes);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_regs(base, size_bytes);
  endtask

  function automatic logic [REQ_W-1:0] pick_request();
    case ($urandom_range(9))
      0: return '0;
      1: return REQ_W'($urandom_range(32768));
      default: return REQ_W'($urandom_range(160, 1));
    endcase
  endfunction

  initial begin
    int start_words;
    int seq_len;
    bit paused;
    paused = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    tx_idle_pct = 15;
    rx_idle_pct = 79;

    // Allocations before any init report not-ready, even with a zero size.
    send_word(ACT_ALLOC, 16'd0);
    send_word(ACT_ALLOC, 16'd32768);
    send_word(ACT_INIT, 16'd12345);
    send_word(ACT_ALLOC, 16'd0);
    send_word(ACT_ALLOC, 16'd1);
    send_word(ACT_ALLOC, 16'd7);
    send_word(ACT_ALLOC, 16'd8);
    send_word(ACT_ALLOC, 16'd32768);
    send_word(ACT_ALLOC, 16'd32767);
    // This leaves a trailing free node of size zero.
    send_word(ACT_ALLOC, 16'd32688);
    send_word(ACT_ALLOC, 16'd1);
    send_word(ACT_INIT, 16'd0);
    send_word(ACT_ALLOC, 16'd32759);
    wait_drained();
    // The smallest heap at the top base, so the address wraps.
    set_config(32'hFFFF_FFF8, 16'd16);
    send_word(ACT_INIT, 16'd0);
    send_word(ACT_ALLOC, 16'd1);
    send_word(ACT_ALLOC, 16'd1);
    wait_drained();
    set_config(32'h0000_0005, 16'd32);
    send_word(ACT_INIT, 16'd0);
    send_word(ACT_ALLOC, 16'd8);
    send_word(ACT_ALLOC, 16'd1);
    send_word(ACT_ALLOC, 16'd15);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        tx_idle_pct = 15;
        rx_idle_pct = 79;
      end else if (ph < 8) begin
        tx_idle_pct = 79;
        rx_idle_pct = 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (ph % 4)
        0: set_config(ph == 0 ? 32'h0 : ($urandom & 32'hFFFF_FFF8), 16'd32768);
        1: set_config(32'hFFFF_FFF8, 16'd16);
        2: set_config($urandom & 32'hFFFF_FFF8, SIZE_W'($urandom_range(512, 16)));
        default: set_config($urandom, SIZE_W'($urandom_range(32768, 16)));
      endcase
      if (ph == 1 || ph == 9) rx_hold_req = 1'b1;
      start_words = words_sent;
      while (words_sent - start_words < WORDS_PER_PHASE) begin
        if ($urandom_range(9) != 0) begin
          send_word(ACT_INIT, REQ_W'($urandom));
          seq_len = $urandom_range(30, 1);
          repeat (seq_len) send_word(ACT_ALLOC, pick_request());
        end else begin
          seq_len = $urandom_range(6, 1);
          repeat (seq_len) send_word(1'($urandom_range(1)), REQ_W'($urandom_range(32768)));
        end
        if (ph == 5 && !paused && words_sent - start_words > WORDS_PER_PHASE / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    repeat (16) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
